// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int RADIX_W         = 6;
   localparam int CHAR_W          = 7;
   // quotient bits resolved per divider cycle
   localparam int BITS_PER_CYCLE  = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_RADIX = '0;

   localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET    = 6'd10;
   localparam logic [RADIX_W-1:0] DECIMAL_BASE   = 6'd10;
   localparam logic [RADIX_W-1:0] LAST_DEC_DIGIT = 6'd9;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd65;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;

   typedef struct packed {
      logic start;      // load a new request
      logic div_step;   // one group of quotient bits
      logic div_end;    // final group: store digit, keep quotient
      logic rd_issue;   // read digit store at the read pointer
      logic out_minus;  // load '-' into the output register
      logic out_digit;  // load the read digit into the output register
   } cmd_type;

   typedef struct packed {
      logic quot_zero;  // quotient of the group in progress is zero
      logic minus;      // sign character owed
      logic rd_last;    // digit just read is the least significant one
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {1'b0, d};
      if (d > LAST_DEC_DIGIT) begin
         return ext - CHAR_W'(DECIMAL_BASE) + CHAR_LETTER;
      end
      return ext + CHAR_ZERO;
   endfunction

endpackage

// File: rtl/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: sign handling, radix divider, digit store and output register.
// ----------------------------------------------------------------------------
module itoa_dp #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  itoa_pkg::cmd_type                 cmd,
   output itoa_pkg::status_type              status,
   input  logic [itoa_pkg::RADIX_W-1:0]      radix,
   input  logic signed [VALUE_WIDTH-1:0]     number,
   output logic [itoa_pkg::CHAR_W-1:0]       character,
   output logic                              last
);
   import itoa_pkg::*;

   localparam int GROUPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int PAD_W  = GROUPS * BITS_PER_CYCLE;
   localparam int AW     = $clog2(VALUE_WIDTH);
   localparam int CW     = $clog2(VALUE_WIDTH + 1);

   logic [RADIX_W-1:0] radix_sat;
   logic [VALUE_WIDTH-1:0] mag;
   logic neg;

   logic [PAD_W-1:0]   shift_ff, shift_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic               minus_ff;
   logic [RADIX_W-1:0] rd_data_ff;
   logic               rd_last_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;

   logic [RADIX_W-1:0] dstore [VALUE_WIDTH];

   always_comb begin
      if (radix < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = radix;
      end
   end

   // only base ten prints a sign; other bases take the raw pattern
   assign neg = (radix_sat == DECIMAL_BASE) && number[VALUE_WIDTH-1];
   assign mag = neg ? (~number + VALUE_WIDTH'(1)) : number;

   // restoring division, BITS_PER_CYCLE quotient bits a cycle; the remainder
   // stays below the radix so each step is a narrow compare and subtract
   always_comb begin
      logic [RADIX_W:0]   t;
      logic [PAD_W-1:0]   sh;
      logic [RADIX_W-1:0] r;
      sh = shift_ff;
      r  = rem_ff;
      for (int k = 0; k < BITS_PER_CYCLE; k++) begin
         t  = {r, sh[PAD_W-1]};
         sh = sh << 1;
         if (t >= {1'b0, radix_sat}) begin
            t     = t - {1'b0, radix_sat};
            sh[0] = 1'b1;
         end
         r = t[RADIX_W-1:0];
      end
      shift_in = sh;
      rem_in   = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         minus_ff <= 1'b0;
      end else if (cmd.start) begin
         count_ff <= '0;
         minus_ff <= neg;
      end else begin
         if (cmd.div_end) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.out_minus) begin
            minus_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         shift_ff <= PAD_W'(mag);
         rem_ff   <= '0;
      end else if (cmd.div_end) begin
         shift_ff <= shift_in;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
      if (cmd.div_end) begin
         rd_ptr_ff <= count_ff[AW-1:0];
      end else if (cmd.out_digit) begin
         rd_ptr_ff <= rd_ptr_ff - AW'(1);
      end
   end

   // digit store, least significant digit at entry zero
   always_ff @(posedge clock) begin
      if (cmd.div_end) begin
         dstore[count_ff[AW-1:0]] <= rem_in;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= dstore[rd_ptr_ff];
         rd_last_ff <= (rd_ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_minus) begin
         char_ff <= CHAR_MINUS;
         last_ff <= 1'b0;
      end else if (cmd.out_digit) begin
         char_ff <= digit_to_ascii(rd_data_ff);
         last_ff <= rd_last_ff;
      end
   end

   assign status.quot_zero = (shift_in == '0);
   assign status.minus     = minus_ff;
   assign status.rd_last   = rd_last_ff;
   assign character        = char_ff;
   assign last             = last_ff;

endmodule

// File: rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences division, sign and digit emission per request.
// ----------------------------------------------------------------------------
module itoa_ctrl #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output itoa_pkg::cmd_type    cmd,
   input  itoa_pkg::status_type status
);
   import itoa_pkg::*;

   localparam int GROUPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int GCNT_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [GCNT_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              out_free;
   logic              group_end;

   assign out_free  = !valid_ff || !rsp_stall;
   assign group_end = (step_ff == GCNT_W'(GROUPS - 1));

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               step_in   = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (group_end) begin
               cmd.div_end = 1'b1;
               step_in     = '0;
               if (status.quot_zero) begin
                  state_in = status.minus ? ST_SIGN : ST_READ;
               end
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + GCNT_W'(1);
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.out_minus = 1'b1;
               valid_in      = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_digit = 1'b1;
               valid_in      = 1'b1;
               state_in      = status.rd_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// File: rtl/int_to_ascii_any_base.sv
// ----------------------------------------------------------------------------
// int_to_ascii_any_base
// Converts a two's complement integer to its text in base 2 to 36,
// most significant character first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_number
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_character, rsp_last
//  csr     | in/out    | APB, pready tied hi  | radix at byte address 0
//
//  One request at a time. Each digit is found by a run of divider steps,
//  eight quotient bits per step; then each character takes a digit store
//  read and an output load, with a '-' first for a negative decimal number.
//  The divider loop sets most of the conversion time.
//  The next request is taken while the final character still waits.
//  Synchronous reset clears control state and sets the radix to ten.
//  rsp_stall holds the output register; the sequence waits behind it.
// ----------------------------------------------------------------------------
module int_to_ascii_any_base #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [VALUE_WIDTH-1:0]       req_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [itoa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [itoa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [itoa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import itoa_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [RADIX_W-1:0] radix_ff;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_idx == REG_RADIX) begin
         radix_ff <= csr_pwdata[RADIX_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == REG_RADIX) begin
         csr_prdata = CSR_DATA_W'(radix_ff);
      end
   end

   itoa_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   itoa_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .radix     (radix_ff),
      .number    (req_number),
      .character (rsp_character),
      .last      (rsp_last)
   );

`ifndef SYNTH
   // a taken request must close the input until its text is built
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after a request was taken");

   // the sign always has digits after it
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("sign character flagged as last");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS
                     || (rsp_character >= CHAR_ZERO && rsp_character <= 7'd57)
                     || (rsp_character >= CHAR_LETTER && rsp_character <= 7'd90)))
      else $error("character outside the digit alphabet");
`endif

endmodule

// File: dv/int_to_ascii_any_base_tb.sv
// ----------------------------------------------------------------------------
// int_to_ascii_any_base_tb
// Self-checking bench for the integer to text converter. Numbers are sent
// through the request channel under a series of radix settings (including
// out-of-range values that saturate). Each accepted request is expanded into
// its expected characters, and every character leaving the block is checked
// in order. Both sides idle at random; the receiver blocks once for long.
// ----------------------------------------------------------------------------
module int_to_ascii_any_base_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itoa_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned HOLD_AFTER     = 40;
   localparam int unsigned RANDOM_PER_SET = 21;
   localparam int unsigned DRAIN_CYCLES   = 250;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_number  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [31:0]           number_q[$];   // numbers waiting to be offered
   text_char_type         text_q[$];     // characters still owed by the block
   logic [RADIX_W-1:0]    radix_shadow = RADIX_RESET;

   int unsigned numbers_taken = 0;
   int unsigned chars_checked = 0;
   int unsigned settings_run  = 0;
   int unsigned error_count   = 0;
   int unsigned req_gap       = 0;
   int unsigned stall_left    = 0;
   int unsigned calm_left     = 0;
   int unsigned quiet_cycles  = 0;
   logic        calm          = 1'b0;
   logic        long_hold_done = 1'b0;

   int_to_ascii_any_base u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // radix actually used by the block: clamped to 2..36
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end
      if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      if (d > LAST_DEC_DIGIT) begin
         return CHAR_LETTER + CHAR_W'(d - DECIMAL_BASE);
      end
      return CHAR_ZERO + CHAR_W'(d);
   endfunction

   // expand one number into the characters it must produce
   task automatic queue_text(input logic [31:0] num);
      logic [RADIX_W-1:0] base;
      logic [31:0]        mag;
      logic [RADIX_W-1:0] digits [0:31];
      logic               negative;
      int                 ndig;
      int                 i;
      text_char_type      tc;
      base     = clamp_radix(radix_shadow);
      negative = (base == DECIMAL_BASE) && num[31];
      mag      = negative ? (32'd0 - num) : num;
      ndig     = 0;
      if (mag == 0) begin
         digits[0] = '0;
         ndig      = 1;
      end
      while (mag != 0) begin
         digits[ndig] = RADIX_W'(mag % base);
         mag          = mag / base;
         ndig++;
      end
      if (negative) begin
         tc.code = CHAR_MINUS;
         tc.last = 1'b0;
         text_q.push_back(tc);
      end
      for (i = ndig - 1; i >= 0; i--) begin
         tc.code = digit_char(digits[i]);
         tc.last = (i == 0);
         text_q.push_back(tc);
      end
   endtask

   // mostly short gaps, now and then a long one; none while calm
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] random_number(input logic [RADIX_W-1:0] r);
      logic [63:0] p;
      int unsigned k;
      logic [RADIX_W-1:0] base;
      base = clamp_radix(r);
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom;
         3: return $urandom_range(0, 1000);
         4: return 32'd0 - $urandom_range(1, 1000);
         5: begin
            // a power of the radix, or one below it
            p = 64'd1;
            k = $urandom_range(1, 32);
            while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
               p = p * base;
               k--;
            end
            return p[31:0] - $urandom_range(0, 1);
         end
         6: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      logic free;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            queue_text(req_number);
            numbers_taken++;
            free = 1'b1;
         end
         if (free) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (number_q.size() > 0) begin
               req_valid  <= 1'b1;
               req_number <= number_q.pop_front();
               req_gap    <= idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long block once traffic is flowing
   always @(posedge clock) begin : drive_stall
      int unsigned len;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && numbers_taken >= HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         rsp_stall      <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
      end else begin
         len = idle_len();
         rsp_stall  <= (len > 0);
         stall_left <= (len > 0) ? len - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(50, 400);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // character checker
   always @(posedge clock) begin : check_rsp
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_checked++;
         if (text_q.size() == 0) begin
            $error("unexpected character 0x%0h (last %0b)", rsp_character, rsp_last);
            error_count++;
         end else begin
            want = text_q.pop_front();
            if (rsp_character !== want.code) begin
               $error("character: expected 0x%0h, got 0x%0h", want.code, rsp_character);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (number_q.size() != 0 || req_valid || text_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_radix(input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_RADIX, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      radix_shadow = value[RADIX_W-1:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      // read back
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== CSR_DATA_W'(radix_shadow)) begin
         $error("radix readback: expected %0d, got %0d", radix_shadow, csr_prdata);
         error_count++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] settings [0:15];
      int                 s;
      int                 j;
      settings = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd63, 6'd37,
                   6'd8, 6'd3, 6'd7, 6'd35, 6'd10, 6'd11, 6'd0, 6'd0};
      settings[14] = RADIX_W'($urandom_range(0, 63));
      settings[15] = RADIX_W'($urandom_range(2, 36));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // decimal at reset: sign handling and field extremes
      number_q.push_back(32'd0);
      number_q.push_back(32'd1);
      number_q.push_back(32'hFFFF_FFFF);
      number_q.push_back(32'd9);
      number_q.push_back(32'd10);
      number_q.push_back(32'd0 - 32'd10);
      number_q.push_back(32'h7FFF_FFFF);
      number_q.push_back(32'h8000_0000);
      number_q.push_back(32'h8000_0001);
      number_q.push_back(32'd123456789);
      number_q.push_back(32'd0 - 32'd987654321);
      number_q.push_back(32'd1000000000);
      number_q.push_back(32'd35);
      number_q.push_back(32'd36);
      number_q.push_back(32'h5555_5555);
      number_q.push_back(32'hAAAA_AAAA);

      for (s = 0; s < 16; s++) begin
         if (s > 0) begin
            wait_drained();
            // junk in the upper bits must be ignored
            write_radix({(CSR_DATA_W - RADIX_W)'($urandom), settings[s]});
            number_q.push_back(32'd0);
            number_q.push_back(32'hFFFF_FFFF);
            number_q.push_back(32'h7FFF_FFFF);
            number_q.push_back(32'h8000_0000);
            number_q.push_back(32'(clamp_radix(settings[s])));
         end
         for (j = 0; j < RANDOM_PER_SET; j++) begin
            number_q.push_back(random_number(settings[s]));
         end
         settings_run++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d numbers converted into %0d checked characters", numbers_taken,
               chars_checked);
      $display("%0d radix settings, saturating values included; %0d mismatches",
               settings_run, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
